// ----- src/mrwd_pkg.sv -----
// Package for the mouse report builder with wheel debouncing.
// Holds the item types, opcode, event code and register index constants.
// No dependencies.
package mrwd_pkg;

  // Opcodes of an input item.
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_REL   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Event codes.
  localparam logic [3:0] KEY_MIDDLE = 4'd2;
  localparam logic [3:0] REL_X      = 4'd0;
  localparam logic [3:0] REL_Y      = 4'd1;
  localparam logic [3:0] REL_WHEEL  = 4'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBOUNCE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_WHEEL_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] WHEEL_THRESHOLD_RST = 16'd45;
  localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd500;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } wheel_dir_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         event_code;
    logic signed [31:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         buttons;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [15:0] wheel;
    logic [1:0]         wheel_direction;
  } out_item_t;

endpackage

// ----- src/mouse_report_with_wheel_debounce.sv -----
// Mouse report builder with wheel direction debouncing, top level.
// Depends on mrwd_pkg for the item types and constants.
//
// This block turns a stream of input events into mouse reports. Every accepted
// item yields exactly one result item that carries the report after that
// event: the button bitmap, the saturated x, y and wheel sums and the wheel
// debouncer's direction. Key events with a code below 8 set or clear a button bit; a key event for
// the middle button also resets the debouncer to idle with an empty
// accumulator. Relative events add to x, y or wheel with 16-bit saturation.
// With debouncing enabled, a wheel amount goes into a 32-bit saturating
// accumulator and passes only if it continues the current direction or the
// accumulated magnitude reaches wheel_threshold; each wheel event
// restarts a timeout of timeout_ticks tick items, after which the direction
// falls back to idle. Throughput is one item per clock cycle while the output
// is not stalled. An item is held in the input register and its result is
// registered in the output register; the rate is set by the single pass of
// the accumulator add, magnitude compare and saturating sum add between those
// two registers. The output register lets a new item enter while a finished
// result still waits to be taken. The configuration port is always ready;
// registers should be written only while the block is idle.
module mouse_report_with_wheel_debounce
  import mrwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,

  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic signed [32:0] ACC_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] ACC_MIN = -33'sh0_8000_0000;
  localparam logic signed [33:0] SUM_MAX = 34'sd32767;
  localparam logic signed [33:0] SUM_MIN = -34'sd32768;

  // Configuration registers.
  logic        debounce_enable_r;
  logic [15:0] wheel_threshold_r;
  logic [15:0] timeout_ticks_r;

  // Input register.
  logic        s0_valid_r;
  in_item_t    s0_item_r;

  // Report and debouncer state.
  logic [7:0]         buttons_r,   buttons_nxt;
  logic signed [15:0] sum_x_r,     sum_x_nxt;
  logic signed [15:0] sum_y_r,     sum_y_nxt;
  logic signed [15:0] sum_wheel_r, sum_wheel_nxt;
  logic signed [31:0] acc_r,       acc_nxt;
  wheel_dir_t         dir_r,       dir_nxt;
  logic [15:0]        timer_r,     timer_nxt;

  // Output register.
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        advance;

  // Debouncer datapath.
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic [32:0]        acc_mag;
  logic               continues;
  logic               reaches;
  logic signed [31:0] wheel_amt;

  // Shared saturating adder for x, y and wheel.
  logic signed [15:0] add_base;
  logic signed [31:0] add_amt;
  logic signed [33:0] add_sum;
  logic signed [15:0] add_sat;

  // The item in the input register moves on when the output register is
  // empty or its result is being taken in this cycle.
  assign advance   = s0_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s0_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_enable_r <= 1'b0;
      wheel_threshold_r <= WHEEL_THRESHOLD_RST;
      timeout_ticks_r   <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE_ENABLE: debounce_enable_r <= cfg_data[0];
        CFG_WHEEL_THRESHOLD: wheel_threshold_r <= cfg_data;
        CFG_TIMEOUT_TICKS:   timeout_ticks_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accumulate the wheel amount with 32-bit saturation and measure the
  // magnitude one bit wider so the most negative value compares correctly.
  always_comb begin
    acc_sum = 33'(acc_r) + 33'(s0_item_r.event_value);
    if (acc_sum > ACC_MAX) begin
      acc_sat = ACC_MAX[31:0];
    end else if (acc_sum < ACC_MIN) begin
      acc_sat = ACC_MIN[31:0];
    end else begin
      acc_sat = acc_sum[31:0];
    end
    acc_mag   = acc_sat[31] ? 33'(-(33'(acc_sat))) : {1'b0, acc_sat};
    continues = ((dir_r == DIR_UP) && (acc_sat > 32'sd0)) ||
                ((dir_r == DIR_DOWN) && (acc_sat < 32'sd0));
    reaches   = acc_mag >= {17'd0, wheel_threshold_r};
    if (!debounce_enable_r) begin
      wheel_amt = s0_item_r.event_value;
    end else if (continues || reaches) begin
      wheel_amt = acc_sat;
    end else begin
      wheel_amt = 32'sd0;
    end
  end

  always_comb begin
    case (s0_item_r.event_code)
      REL_X:   add_base = sum_x_r;
      REL_Y:   add_base = sum_y_r;
      default: add_base = sum_wheel_r;
    endcase
    add_amt = (s0_item_r.event_code == REL_WHEEL) ? wheel_amt : s0_item_r.event_value;
    add_sum = 34'(add_base) + 34'(add_amt);
    if (add_sum > SUM_MAX) begin
      add_sat = SUM_MAX[15:0];
    end else if (add_sum < SUM_MIN) begin
      add_sat = SUM_MIN[15:0];
    end else begin
      add_sat = add_sum[15:0];
    end
  end

  always_comb begin
    buttons_nxt   = buttons_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    sum_wheel_nxt = sum_wheel_r;
    acc_nxt       = acc_r;
    dir_nxt       = dir_r;
    timer_nxt     = timer_r;
    case (s0_item_r.opcode)
      OP_KEY: begin
        // The middle button resets the debouncer; a running timer keeps going.
        if (s0_item_r.event_code == KEY_MIDDLE) begin
          dir_nxt = DIR_IDLE;
          acc_nxt = 32'sd0;
        end
        if (!s0_item_r.event_code[3]) begin
          buttons_nxt[s0_item_r.event_code[2:0]] = (s0_item_r.event_value != 32'sd0);
        end
      end
      OP_REL: begin
        case (s0_item_r.event_code)
          REL_X: sum_x_nxt = add_sat;
          REL_Y: sum_y_nxt = add_sat;
          REL_WHEEL: begin
            sum_wheel_nxt = add_sat;
            if (debounce_enable_r) begin
              timer_nxt = timeout_ticks_r;
              if (continues) begin
                acc_nxt = 32'sd0;
              end else if (reaches) begin
                acc_nxt = 32'sd0;
                dir_nxt = (acc_sat > 32'sd0) ? DIR_UP : DIR_DOWN;
              end else begin
                acc_nxt = acc_sat;
              end
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        // The timer runs while nonzero; reaching zero sends the direction idle.
        if (timer_r != 16'd0) begin
          timer_nxt = timer_r - 16'd1;
          if (timer_r == 16'd1) begin
            dir_nxt = DIR_IDLE;
          end
        end
      end
      OP_CLEAR: begin
        sum_x_nxt     = 16'sd0;
        sum_y_nxt     = 16'sd0;
        sum_wheel_nxt = 16'sd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s0_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_r   <= 8'd0;
      sum_x_r     <= 16'sd0;
      sum_y_r     <= 16'sd0;
      sum_wheel_r <= 16'sd0;
      acc_r       <= 32'sd0;
      dir_r       <= DIR_IDLE;
      timer_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      buttons_r   <= buttons_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_wheel_r <= sum_wheel_nxt;
      acc_r       <= acc_nxt;
      dir_r       <= dir_nxt;
      timer_r     <= timer_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The result carries the report as it stands after the item.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.buttons         <= buttons_nxt;
      out_item_r.move_x          <= sum_x_nxt;
      out_item_r.move_y          <= sum_y_nxt;
      out_item_r.wheel           <= sum_wheel_nxt;
      out_item_r.wheel_direction <= dir_nxt;
    end
  end

endmodule

// ----- sim/mouse_report_checker.sv -----
// Scoreboard for the mouse report builder: predicts the report for every accepted event item
// and compares it with the block's result items. Depends on mrwd_pkg.
`timescale 1ns / 1ps
module mouse_report_checker
  import mrwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          reports_pending
);

  localparam int BUTTON_COUNT = 8;
  localparam longint ACC_MAX  = 64'sd2147483647;
  localparam longint ACC_MIN  = -64'sd2147483648;

  // Register copies.
  logic        debounce_on;
  logic [15:0] threshold;
  logic [15:0] timeout_load;

  // Report and debouncer state.
  logic [7:0]         buttons;
  logic signed [15:0] x_sum;
  logic signed [15:0] y_sum;
  logic signed [15:0] wheel_sum;
  logic signed [31:0] wheel_acc;
  wheel_dir_t         direction;
  logic [15:0]        ticks_left;

  out_item_t expected_reports[$];

  function automatic logic signed [15:0] sat_sum16(logic signed [15:0] base, longint delta);
    longint t;
    t = longint'(base) + delta;
    if (t > 32767) t = 32767;
    else if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  function automatic out_item_t predict_report(in_item_t ev);
    longint    amount;
    longint    acc;
    longint    mag;
    out_item_t rep;
    amount = longint'($signed(ev.event_value));
    case (ev.opcode)
      OP_KEY: begin
        if (ev.event_code == KEY_MIDDLE) begin
          direction = DIR_IDLE;
          wheel_acc = '0;
        end
        if (ev.event_code < BUTTON_COUNT)
          buttons[ev.event_code[2:0]] = (ev.event_value != 0);
      end
      OP_REL: begin
        if (ev.event_code == REL_X) begin
          x_sum = sat_sum16(x_sum, amount);
        end else if (ev.event_code == REL_Y) begin
          y_sum = sat_sum16(y_sum, amount);
        end else if (ev.event_code == REL_WHEEL) begin
          if (debounce_on) begin
            acc = longint'(wheel_acc) + amount;
            if (acc > ACC_MAX) acc = ACC_MAX;
            else if (acc < ACC_MIN) acc = ACC_MIN;
            mag = (acc < 0) ? -acc : acc;
            if ((direction == DIR_UP && acc > 0) || (direction == DIR_DOWN && acc < 0)) begin
              amount = acc;
              acc = 0;
            end else if (mag >= longint'(threshold)) begin
              direction = (acc > 0) ? DIR_UP : DIR_DOWN;
              amount = acc;
              acc = 0;
            end else begin
              amount = 0;
            end
            wheel_acc = acc[31:0];
            ticks_left = timeout_load;
          end
          wheel_sum = sat_sum16(wheel_sum, amount);
        end
      end
      OP_TICK: begin
        if (ticks_left != 0) begin
          ticks_left = ticks_left - 1'b1;
          if (ticks_left == 0) direction = DIR_IDLE;
        end
      end
      default: begin
        x_sum = '0;
        y_sum = '0;
        wheel_sum = '0;
      end
    endcase
    rep.buttons = buttons;
    rep.move_x = x_sum;
    rep.move_y = y_sum;
    rep.wheel = wheel_sum;
    rep.wheel_direction = direction;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      debounce_on = 1'b0;
      threshold = WHEEL_THRESHOLD_RST;
      timeout_load = TIMEOUT_TICKS_RST;
      buttons = '0;
      x_sum = '0;
      y_sum = '0;
      wheel_sum = '0;
      wheel_acc = '0;
      direction = DIR_IDLE;
      ticks_left = '0;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result item with no expected report waiting");
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("buttons", 17'(want.buttons), 17'(out_item.buttons));
          check_field("move_x", 17'(want.move_x), 17'(out_item.move_x));
          check_field("move_y", 17'(want.move_y), 17'(out_item.move_y));
          check_field("wheel", 17'(want.wheel), 17'(out_item.wheel));
          check_field("wheel_direction", 17'(want.wheel_direction),
                      17'(out_item.wheel_direction));
        end
      end
      if (in_valid && !in_stall) expected_reports.push_back(predict_report(in_item));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE_ENABLE: debounce_on = cfg_data[0];
          CFG_WHEEL_THRESHOLD: threshold = cfg_data;
          CFG_TIMEOUT_TICKS:   timeout_load = cfg_data;
          default: ;
        endcase
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

// ----- sim/mouse_report_with_wheel_debounce_test.sv -----
// Testbench top for the mouse report builder: drives event items and register writes,
// stalls the result side, and reports the verdict. Depends on mrwd_pkg and mouse_report_checker.
`timescale 1ns / 1ps
module mouse_report_with_wheel_debounce_test
  import mrwd_pkg::*;
();

  // Cycles without any accepted item or register write before the run is declared hung.
  // The longest legal quiet stretch is a sender gap, a run of receiver stalls or the
  // short settle wait between phases, all far below this.
  localparam int QUIET_LIMIT = 2000;

  // Receiver stall patterns.
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatch_count;
  int reports_pending;
  int burst_left = 0;
  int stall_mode = STALL_NONE;
  int stall_span = 0;
  int quiet_cycles = 0;

  mouse_report_with_wheel_debounce dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mouse_report_checker report_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  always #2 clk = ~clk;

  // The receiver switches between stall patterns, each held for a random span: no stalls
  // at all, an occasional stall, or mostly stalled. This puts back-pressure on every phase
  // of the pipeline and also leaves long stretches at full rate.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_span = $urandom_range(10, 60);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= 1'b0;
    endcase
  end

  // Watchdog: any accepted item or register write counts as progress. Inputs and
  // outputs are sampled before this edge's updates, as the block sees them.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("mouse_report_with_wheel_debounce_test NOT OK");
      $finish;
    end
  end

  // Offers one event item and returns at the edge where it is accepted. The sender
  // works in bursts: once a burst is used up, valid drops for a random gap and a new
  // burst length is drawn. Valid stays high between items inside a burst, and the
  // payload is held while the block stalls.
  task automatic send_event(input logic [1:0] op, input logic [3:0] code,
                            input logic [31:0] value);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_item <= '{op, code, value};
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Writes all three registers back to back. Only called while the block is idle.
  task automatic load_config(input bit enable, input logic [15:0] thr, input logic [15:0] ticks);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DEBOUNCE_ENABLE;
    cfg_data <= {15'd0, enable};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_WHEEL_THRESHOLD;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stops sending and waits until every expected report has come back, so that
  // nothing is still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (reports_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          pick;
    logic [1:0]  op;
    logic [3:0]  code;
    logic [31:0] value;

    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEBOUNCE_ENABLE;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. First with the registers at their reset values, so debouncing
    // is off: button set and clear, a key code outside the buttons, saturation of x
    // at both ends and of y at the low end, a wheel amount passing straight through,
    // an ignored relative code, a tick with no timer running, clear, and the middle button.
    send_event(OP_KEY, 4'd0, 32'd1);
    send_event(OP_KEY, 4'd7, 32'h8000_0000);
    send_event(OP_KEY, 4'd9, 32'd1);
    send_event(OP_KEY, 4'd0, 32'd0);
    send_event(OP_REL, REL_X, 32'h7FFF_FFFF);
    send_event(OP_REL, REL_X, 32'h8000_0000);
    send_event(OP_REL, REL_Y, -32'sd40000);
    send_event(OP_REL, REL_WHEEL, 32'd100);
    send_event(OP_REL, 4'd15, 32'd5);
    send_event(OP_TICK, 4'd0, 32'd0);
    send_event(OP_CLEAR, 4'd15, 32'hFFFF_FFFF);
    send_event(OP_KEY, KEY_MIDDLE, 32'd1);
    settle();

    // Debouncing on with a small threshold and a three-tick timeout: a wheel amount
    // held back below the threshold, the threshold reached, continuation in the same
    // direction, a reversal held back, timer expiry, accumulator saturation at the
    // negative end, and the middle button putting the debouncer back to idle.
    load_config(1'b1, 16'd10, 16'd3);
    send_event(OP_REL, REL_WHEEL, 32'd4);
    send_event(OP_REL, REL_WHEEL, 32'd7);
    send_event(OP_REL, REL_WHEEL, 32'd1);
    send_event(OP_REL, REL_WHEEL, -32'sd3);
    send_event(OP_TICK, 4'd0, 32'd0);
    send_event(OP_TICK, 4'd0, 32'd0);
    send_event(OP_TICK, 4'd0, 32'd0);
    send_event(OP_REL, REL_WHEEL, 32'h8000_0000);
    send_event(OP_REL, REL_WHEEL, 32'h7FFF_FFFF);
    send_event(OP_KEY, KEY_MIDDLE, 32'd0);
    settle();

    // A zero threshold lets every wheel event through, and an empty accumulator then
    // turns the direction to down. A zero timeout leaves the timer stopped.
    load_config(1'b1, 16'd0, 16'd0);
    send_event(OP_REL, REL_WHEEL, 32'd0);
    send_event(OP_TICK, 4'd0, 32'd0);
    settle();

    // Largest threshold and timeout.
    load_config(1'b1, 16'hFFFF, 16'hFFFF);
    send_event(OP_REL, REL_WHEEL, 32'd30000);
    send_event(OP_REL, REL_WHEEL, 32'd40000);
    send_event(OP_REL, REL_WHEEL, 32'h8000_0000);
    settle();

    // Random part: six phases of a hundred items each, each under its own register
    // setting. Most items are small wheel, x and y movements, ticks and button events,
    // which keep the debouncer going through its states and let the timer expire.
    // The rest are full-range values, unused codes and arbitrary items.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       load_config(1'b0, 16'($urandom_range(1, 65535)),
                             16'($urandom_range(1, 65535)));
        2:       load_config(1'b1, 16'd1, 16'd1);
        3:       load_config(1'b1, 16'hFFFF, 16'hFFFF);
        5:       load_config(1'b1, 16'($urandom_range(1, 200)), 16'($urandom_range(1, 50)));
        default: load_config(1'b1, 16'($urandom_range(1, 60)), 16'($urandom_range(1, 20)));
      endcase
      repeat (100) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          op = OP_REL;
          code = REL_WHEEL;
          value = (pick < 4) ? $urandom() : $urandom_range(0, 40) - 20;
        end else if (pick < 50) begin
          op = OP_TICK;
          code = 4'($urandom_range(0, 15));
          value = (pick < 40) ? $urandom() : 32'd0;
        end else if (pick < 62) begin
          op = OP_KEY;
          code = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) :
                                                4'($urandom_range(0, 7));
          value = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 1);
        end else if (pick < 82) begin
          op = OP_REL;
          code = 4'($urandom_range(REL_X, REL_Y));
          value = (pick < 66) ? $urandom() : $urandom_range(0, 4000) - 2000;
        end else if (pick < 87) begin
          op = OP_REL;
          code = 4'($urandom_range(3, 15));
          value = $urandom();
        end else if (pick < 90) begin
          op = OP_CLEAR;
          code = 4'($urandom_range(0, 15));
          value = $urandom();
        end else begin
          op = 2'($urandom_range(0, 3));
          code = 4'($urandom_range(0, 15));
          value = $urandom();
        end
        send_event(op, code, value);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("mouse_report_with_wheel_debounce_test OK");
    end else begin
      $display("mouse_report_with_wheel_debounce_test NOT OK");
    end
    $finish;
  end

endmodule
